FILE: sv/fucr_pkg.sv
// Shared constants, codes and CRC helpers for the framed command receiver.
package fucr_pkg;

  // Framing and command bytes
  localparam logic [7:0] PREAMBLE      = 8'hAA;
  localparam logic [7:0] CMD_WRITE_ALL = 8'h02;
  localparam logic [7:0] CMD_WRITE_DEV = 8'h04;
  localparam logic [7:0] CRC_POLY      = 8'hB2;
  localparam logic [7:0] NO_SEQUENCE   = 8'hFF;

  // Known device registers
  localparam logic [7:0] REG_20 = 8'h20;
  localparam logic [7:0] REG_21 = 8'h21;
  localparam logic [7:0] REG_22 = 8'h22;
  localparam logic [7:0] REG_30 = 8'h30;
  localparam logic [7:0] REG_31 = 8'h31;
  localparam logic [7:0] REG_32 = 8'h32;

  // Result status codes
  localparam logic [2:0] ST_LEN_DROP    = 3'd0;
  localparam logic [2:0] ST_BAD_SUM     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN_CMD = 3'd2;
  localparam logic [2:0] ST_WRITE_ALL   = 3'd3;
  localparam logic [2:0] ST_SHORT       = 3'd4;
  localparam logic [2:0] ST_BAD_CRC     = 3'd5;
  localparam logic [2:0] ST_OK          = 3'd6;
  localparam logic [2:0] ST_UNKNOWN_REG = 3'd7;

  // Minimum payload of a write-device frame: reg, lsb, msb, crc
  localparam logic [7:0] WDEV_MIN_PAYLOAD = 8'd4;

  // One byte of the reflected CRC-8, eight bit steps
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC state after the implied write-device command byte
  localparam logic [7:0] CRC_SEED = crc_step(8'h00, CMD_WRITE_DEV);

  function automatic logic known_register(input logic [7:0] r);
    return (r == REG_20) || (r == REG_21) || (r == REG_22) ||
           (r == REG_30) || (r == REG_31) || (r == REG_32);
  endfunction

endpackage

FILE: sv/fucr_ifs.sv
// Stream interfaces for received bytes and for frame results.

interface fucr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fucr_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         command;
  logic [5:0]         payload_length;
  logic [7:0]         register_address;
  logic signed [15:0] register_value;
  logic [7:0]         crc_computed;
  logic               seq_present;
  logic [7:0]         sequence_res;
  logic               replay;

  modport source (output valid, output status, output command, output payload_length,
                  output register_address, output register_value, output crc_computed,
                  output seq_present, output sequence_res, output replay, input ready);
  modport sink   (input valid, input status, input command, input payload_length,
                  input register_address, input register_value, input crc_computed,
                  input seq_present, input sequence_res, input replay, output ready);
endinterface

FILE: sv/framed_uart_command_receiver.sv
// Framed serial command receiver: preamble hunt, length, sum check, write-device decode.
// A result is registered in the cycle after its checksum or bad length byte is accepted.
// Throughput: one byte beat per cycle; the byte is parsed by combinational logic between
// the frame state registers and the result register. Input stalls only while a result
// waits and the sink holds it off. Reset: rst_n (synchronous, active low) returns to the
// preamble hunt, clears counters, sum, CRC, last sequence and the result valid flag.
module framed_uart_command_receiver
  import fucr_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  fucr_byte_if.sink     in_bus,
  fucr_result_if.source out_bus
);

  // Parser phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] last_seq_r, last_seq_nxt;
  logic [7:0] hdr_r [6];

  logic               out_valid_r;
  logic [2:0]         status_r, status_nxt;
  logic [7:0]         command_r, command_nxt;
  logic [5:0]         plen_r, plen_nxt;
  logic [7:0]         reg_r, reg_nxt;
  logic [15:0]        value_r, value_nxt;
  logic [7:0]         crcout_r, crcout_nxt;
  logic               sp_r, sp_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic               rep_r, rep_nxt;

  logic       accept;
  logic       emit;
  logic [7:0] b;
  logic [7:0] full;
  logic [7:0] idx_inc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.rx_byte;
  assign full         = len_r - 8'd1;
  assign idx_inc      = idx_r + 8'd1;

  // Parse one byte beat
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    crc_nxt      = crc_r;
    last_seq_nxt = last_seq_r;
    emit         = 1'b0;
    status_nxt   = ST_LEN_DROP;
    command_nxt  = '0;
    plen_nxt     = '0;
    reg_nxt      = '0;
    value_nxt    = '0;
    crcout_nxt   = '0;
    sp_nxt       = 1'b0;
    seq_nxt      = NO_SEQUENCE;
    rep_nxt      = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (b == PREAMBLE) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = b;
        idx_nxt = '0;
        sum_nxt = '0;
        crc_nxt = CRC_SEED;
        if (b == 8'd0 || b > MAX_LEN) begin
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (idx_r >= 8'd1 && idx_r <= 8'd3) crc_nxt = crc_step(crc_r, b);
        sum_nxt = sum_r + b;
        idx_nxt = idx_inc;
        if (idx_inc >= len_r) phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        phase_nxt   = PH_HUNT;
        emit        = 1'b1;
        command_nxt = hdr_r[0];
        plen_nxt    = full[5:0];
        priority if (b != sum_r) begin
          status_nxt = ST_BAD_SUM;
        end else if (hdr_r[0] == CMD_WRITE_ALL) begin
          status_nxt = ST_WRITE_ALL;
        end else if (hdr_r[0] != CMD_WRITE_DEV) begin
          status_nxt = ST_UNKNOWN_CMD;
        end else if (full < WDEV_MIN_PAYLOAD) begin
          status_nxt = ST_SHORT;
        end else begin
          reg_nxt    = hdr_r[1];
          value_nxt  = {hdr_r[3], hdr_r[2]};
          crcout_nxt = crc_r;
          if (full > WDEV_MIN_PAYLOAD) begin
            sp_nxt  = 1'b1;
            seq_nxt = hdr_r[5];
          end
          if (crc_r != hdr_r[4]) begin
            status_nxt = ST_BAD_CRC;
          end else begin
            if (full > WDEV_MIN_PAYLOAD) begin
              rep_nxt      = (hdr_r[5] == last_seq_r);
              last_seq_nxt = hdr_r[5];
            end
            status_nxt = known_register(hdr_r[1]) ? ST_OK : ST_UNKNOWN_REG;
          end
        end
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      len_r      <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
      crc_r      <= '0;
      last_seq_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      crc_r      <= crc_nxt;
      last_seq_r <= last_seq_nxt;
    end
  end

  // Header bytes: first six frame bytes, each at its own slot
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_DATA && idx_r < 8'd6) begin
      hdr_r[idx_r[2:0]] <= b;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status_r  <= status_nxt;
      command_r <= command_nxt;
      plen_r    <= plen_nxt;
      reg_r     <= reg_nxt;
      value_r   <= value_nxt;
      crcout_r  <= crcout_nxt;
      sp_r      <= sp_nxt;
      seq_r     <= seq_nxt;
      rep_r     <= rep_nxt;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.status           = status_r;
  assign out_bus.command          = command_r;
  assign out_bus.payload_length   = plen_r;
  assign out_bus.register_address = reg_r;
  assign out_bus.register_value   = signed'(value_r);
  assign out_bus.crc_computed     = crcout_r;
  assign out_bus.seq_present      = sp_r;
  assign out_bus.sequence_res     = seq_r;
  assign out_bus.replay           = rep_r;

endmodule
